// ===== design/periodic_multi_timer_table_macros.svh =====
// assertion macros shared by the checker of the periodic timer table
// every macro samples on aclk and is off while aresetn is low
`ifndef PERIODIC_MULTI_TIMER_TABLE_MACROS_SVH
`define PERIODIC_MULTI_TIMER_TABLE_MACROS_SVH

// same-cycle implication
`define PMTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PMTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pmtt_pkg.sv =====
// types and codes of the periodic timer table
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package pmtt_pkg;

    localparam int REQ_W      = 2;
    localparam int ID_W       = 8;
    localparam int PERIOD_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 5;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] elapsed;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ADD  = 6'b000010,
        S_REM  = 6'b000100,
        S_TICK = 6'b001000,
        S_RESP = 6'b010000,
        S_TEND = 6'b100000
    } state_t;

endpackage

// ===== design/pmtt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pmtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== design/periodic_multi_timer_table.sv =====
// channel | dir | tdata (low bit up)                     | tuser    | tlast
// s_axis  | in  | timer_id[7:0], period_ticks[23:8]      | req_type | -
// m_axis  | out | status[1:0], fired_id[9:2], count[14:10]| fired    | last
//
// one entry ram, one read per cycle while a tick is not held: after the accepting
// cycle, add, remove and tick each walk the stored entries, then the response
// register is loaded; a full add or an unused code goes straight to that load
// a tick holds on a fired entry behind a held one while the result register is still full
// reset clears the count and control state, not the slot ram; slots above the count are never read
// the slot table lives in pmtt_ram; depends on pmtt_pkg
`timescale 1ns / 1ps

module periodic_multi_timer_table
    import pmtt_pkg::*;
#(
    parameter int MAX_TIMERS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // timer_id, period_ticks
    input  logic [REQ_W-1:0]      s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // status, fired_id, timer_count, pad
    output logic                  m_axis_tuser,  // fired
    output logic                  m_axis_tlast
);

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [AW-1:0]         ev_addr_reg, ev_addr_next;
    logic                  found_reg, found_next;
    logic                  hold_valid_reg, hold_valid_next;
    logic [ID_W-1:0]       hold_id_reg, hold_id_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ID_W-1:0]       req_id_reg, req_id_next;
    logic [PERIOD_W-1:0]   req_period_reg, req_period_next;
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_fired_reg, out_fired_next;
    logic [ID_W-1:0]       out_fid_reg, out_fid_next;
    logic [CNT_OUT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_load;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    slot_t                 ram_wdata, ram_rdata;

    logic                  accept, out_free, more, full, tk_go, tk_fire;
    logic [CW-1:0]         idx_inc, idx_dec;
    logic [PERIOD_W:0]     tk_sum;
    logic [PERIOD_W-1:0]   tk_e;
    logic [CW+CNT_OUT_W-1:0] cnt_wide;

    pmtt_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(MAX_TIMERS)
    ) u_slots (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign more          = (idx_reg < count_reg);
    assign full          = (count_reg == CW'(MAX_TIMERS));
    assign idx_inc       = idx_reg + CW'(1);
    assign idx_dec       = idx_reg - CW'(1);
    assign tk_sum        = {1'b0, ram_rdata.elapsed} + {{PERIOD_W{1'b0}}, 1'b1};
    assign tk_e          = tk_sum[PERIOD_W-1:0];
    assign tk_fire       = (tk_e >= ram_rdata.period);
    // a fired entry behind a held one needs room in the result register
    assign tk_go         = !ev_valid_reg || !tk_fire || !hold_valid_reg || out_free;
    assign cnt_wide      = {{CNT_OUT_W{1'b0}}, count_reg};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_addr_next    = ev_addr_reg;
        found_next      = found_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        status_next     = status_reg;
        req_id_next     = req_id_reg;
        req_period_next = req_period_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_fired_next  = out_fired_reg;
        out_fid_next    = out_fid_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_id_next     = s_axis_tdata[ID_W-1:0];
                    req_period_next = s_axis_tdata[ID_W+PERIOD_W-1:ID_W];
                    ev_valid_next   = 1'b0;
                    found_next      = 1'b0;
                    hold_valid_next = 1'b0;
                    case (s_axis_tuser)
                        REQ_ADD: begin
                            if (full) begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end else begin
                                idx_next   = count_reg;
                                state_next = S_ADD;
                            end
                        end
                        REQ_REMOVE: begin
                            idx_next   = '0;
                            state_next = S_REM;
                        end
                        REQ_TICK: begin
                            idx_next   = '0;
                            state_next = S_TICK;
                        end
                        default: begin
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end

            S_ADD: begin
                // move entries down by one, oldest first
                if (ev_valid_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = ev_addr_reg + AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (idx_reg != '0) begin
                    ram_re        = 1'b1;
                    ram_raddr     = idx_dec[AW-1:0];
                    ev_valid_next = 1'b1;
                    ev_addr_next  = idx_dec[AW-1:0];
                    idx_next      = idx_dec;
                end else begin
                    ev_valid_next = 1'b0;
                    if (!ev_valid_reg) begin
                        ram_we          = 1'b1;
                        ram_waddr       = '0;
                        ram_wdata.id    = req_id_reg;
                        ram_wdata.period  = req_period_reg;
                        ram_wdata.elapsed = '0;
                        count_next      = count_reg + CW'(1);
                        status_next     = ST_OK;
                        state_next      = S_RESP;
                    end
                end
            end

            S_REM: begin
                // search, then pull the entries behind the match up by one
                if (ev_valid_reg) begin
                    if (found_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = ev_addr_reg - AW'(1);
                        ram_wdata = ram_rdata;
                    end else if (ram_rdata.id == req_id_reg) begin
                        found_next = 1'b1;
                    end
                end
                if (more) begin
                    ram_re        = 1'b1;
                    ram_raddr     = idx_reg[AW-1:0];
                    ev_valid_next = 1'b1;
                    ev_addr_next  = idx_reg[AW-1:0];
                    idx_next      = idx_inc;
                end else begin
                    ev_valid_next = 1'b0;
                    if (!ev_valid_reg) begin
                        if (found_reg) begin
                            count_next  = count_reg - CW'(1);
                            status_next = ST_OK;
                        end else begin
                            status_next = ST_NOT_FOUND;
                        end
                        state_next = S_RESP;
                    end
                end
            end

            S_TICK: begin
                if (tk_go) begin
                    if (ev_valid_reg) begin
                        ram_we            = 1'b1;
                        ram_waddr         = ev_addr_reg;
                        ram_wdata.id      = ram_rdata.id;
                        ram_wdata.period  = ram_rdata.period;
                        ram_wdata.elapsed = tk_fire ? '0 : tk_e;
                        if (tk_fire) begin
                            // the held id is not the last one, send it now
                            if (hold_valid_reg) begin
                                out_load        = 1'b1;
                                out_status_next = ST_OK;
                                out_fired_next  = 1'b1;
                                out_fid_next    = hold_id_reg;
                                out_cnt_next    = cnt_wide[CNT_OUT_W-1:0];
                                out_last_next   = 1'b0;
                            end
                            hold_valid_next = 1'b1;
                            hold_id_next    = ram_rdata.id;
                        end
                    end
                    if (more) begin
                        ram_re        = 1'b1;
                        ram_raddr     = idx_reg[AW-1:0];
                        ev_valid_next = 1'b1;
                        ev_addr_next  = idx_reg[AW-1:0];
                        idx_next      = idx_inc;
                    end else begin
                        ev_valid_next = 1'b0;
                        if (!ev_valid_reg) begin
                            state_next = S_TEND;
                        end
                    end
                end
            end

            S_TEND: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = ST_OK;
                    out_fired_next  = hold_valid_reg;
                    out_fid_next    = hold_valid_reg ? hold_id_reg : '0;
                    out_cnt_next    = cnt_wide[CNT_OUT_W-1:0];
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = status_reg;
                    out_fired_next  = 1'b0;
                    out_fid_next    = '0;
                    out_cnt_next    = cnt_wide[CNT_OUT_W-1:0];
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ev_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ev_valid_reg   <= ev_valid_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        ev_addr_reg    <= ev_addr_next;
        hold_id_reg    <= hold_id_next;
        status_reg     <= status_next;
        req_id_reg     <= req_id_next;
        req_period_reg <= req_period_next;
        out_status_reg <= out_status_next;
        out_fired_reg  <= out_fired_next;
        out_fid_reg    <= out_fid_next;
        out_cnt_reg    <= out_cnt_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, out_cnt_reg, out_fid_reg, out_status_reg};
    assign m_axis_tuser  = out_fired_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== design/pmtt_checker.sv =====
// port-level checks for the periodic timer table, bound to the top level
// depends on pmtt_pkg and periodic_multi_timer_table_macros.svh
`timescale 1ns / 1ps
`include "periodic_multi_timer_table_macros.svh"

module pmtt_checker
    import pmtt_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,  // timer_id, period_ticks
    input logic [REQ_W-1:0]      s_axis_tuser,  // req_type
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,  // status, fired_id, timer_count, pad
    input logic                  m_axis_tuser,  // fired
    input logic                  m_axis_tlast
);

    logic s_take;
    logic [STATUS_W-1:0] out_status;
    logic [ID_W-1:0]     out_fid;

    assign s_take     = s_axis_tvalid && s_axis_tready && (s_axis_tuser == s_axis_tuser)
                        && (s_axis_tdata == s_axis_tdata);
    assign out_status = m_axis_tdata[STATUS_W-1:0];
    assign out_fid    = m_axis_tdata[STATUS_W+ID_W-1:STATUS_W];

    // only fired reports can be followed by more words of the same request
    `PMTT_ASSERT_NOW(a_mid_is_fired, m_axis_tvalid && !m_axis_tlast, m_axis_tuser, "non-last word without fired")
    // a fired report always carries ok status
    `PMTT_ASSERT_NOW(a_fired_ok, m_axis_tvalid && m_axis_tuser, out_status == ST_OK, "fired word with bad status")
    // no fired id shown unless a timer fired
    `PMTT_ASSERT_NOW(a_fid_zero, m_axis_tvalid && !m_axis_tuser, out_fid == '0, "stray fired id")
    // the block is busy right after taking a request
    `PMTT_ASSERT_NEXT(a_busy_after_take, s_take, !s_axis_tready, "ready right after accept")
    `PMTT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")

endmodule

bind periodic_multi_timer_table pmtt_checker u_pmtt_checker (.*);
